// ===== hw/rtl/cnp_pkg.sv =====
// Shared types, constants and helpers of the collision narrow-phase pipeline.
`default_nettype none
package cnp_pkg;

  localparam int unsigned IN_DATA_W  = 256;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 72;

  typedef enum logic [1:0] {
    KIND_CIRCLE     = 2'd0,
    KIND_BOX        = 2'd1,
    KIND_BOX_CIRCLE = 2'd2,
    KIND_NONE       = 2'd3
  } kind_t;

  localparam logic signed [17:0] ONE_Q16     = 18'sd65536;
  localparam logic signed [17:0] NEG_ONE_Q16 = -18'sd65536;

  // Side information that rides along the square root and divider stages.
  typedef struct packed {
    logic               round;
    logic               ok;
    logic               hit;
    logic               sgx;
    logic               sgy;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [31:0] pen;
    logic        [31:0] lim;
    logic        [31:0] ax;
    logic        [31:0] ay;
  } carry_t;

  function automatic logic signed [31:0] sat_q16(input logic signed [35:0] v);
    if (v > 36'sh07FFFFFFF) begin
      return 32'sh7FFFFFFF;
    end else if (v < -36'sh080000000) begin
      return -32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/collision_narrow_phase.sv =====
// Collision narrow phase: streaming circle/box pair test with contact normal and depth.
//
// Input channel (in_*): one shape pair per transaction. in_tuser carries the pair kind,
// in_tdata the centres and sizes in Q16.16. Result channel (out_*): one transaction per
// pair with the collide flag, the unit contact normal from A to B and the depth.
// Throughput is one pair per cycle while out_tready is high: every stage is a register,
// and the 32-step square root and the two 17-step normal dividers are each unrolled into
// one stage per step.
// Each stage carries a valid bit and advances when it is empty or the next stage moves,
// so when the receiver stalls the results pile up in the stages behind the output and
// in_tready stays high until the pipeline is full. Nothing is dropped or repeated.
// Reset (rst_n low, synchronous) empties the pipeline; there is no other state and no
// configuration.
// Pairs whose shapes do not overlap return zero normal and zero depth.
`default_nettype none
module collision_narrow_phase (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // a_x[31:0], a_y[63:32], b_x[95:64], b_y[127:96], a_half_width[158:128],
  // a_half_height[189:159], b_half_width[220:190], b_half_height[251:221], zero fill
  input  wire logic [cnp_pkg::IN_DATA_W-1:0]  in_tdata,
  // kind[1:0]
  input  wire logic [cnp_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // colliding[0], normal_x[18:1], normal_y[36:19], penetration[68:37], zero fill
  output logic [cnp_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import cnp_pkg::*;

  localparam int S_SQ0  = 6;
  localparam int SQ_N   = 32;
  localparam int S_SQL  = S_SQ0 + SQ_N - 1;
  localparam int S_DV0  = S_SQL + 1;
  localparam int DV_N   = 17;
  localparam int S_DVL  = S_DV0 + DV_N - 1;
  localparam int S_OUT  = S_DVL + 1;
  localparam int N      = S_OUT + 1;

  logic [N-1:0] v_r;
  logic [N-1:0] v_src;
  logic [N:0]   en;

  assign en[N] = out_tready;
  assign v_src = {v_r[N-2:0], in_tvalid};
  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_en
      assign en[g] = !v_r[g] || en[g+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < N; i++) begin
        if (en[i]) begin
          v_r[i] <= v_src[i];
        end
      end
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[S_OUT];

  // Stage 0: centre deltas, size sums and box edges.
  logic signed [31:0] in_ax, in_ay, in_bx, in_by;
  logic        [30:0] in_ahw, in_ahh, in_bhw, in_bhh;
  assign in_ax  = in_tdata[31:0];
  assign in_ay  = in_tdata[63:32];
  assign in_bx  = in_tdata[95:64];
  assign in_by  = in_tdata[127:96];
  assign in_ahw = in_tdata[158:128];
  assign in_ahh = in_tdata[189:159];
  assign in_bhw = in_tdata[220:190];
  assign in_bhh = in_tdata[251:221];

  kind_t              s0_kind_r;
  logic signed [32:0] s0_dx_r, s0_dy_r, s0_xmin_r, s0_xmax_r, s0_ymin_r, s0_ymax_r;
  logic        [31:0] s0_rs_r, s0_rh_r;
  logic signed [31:0] s0_bx_r, s0_by_r;
  logic        [30:0] s0_ahw_r, s0_bhw_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_kind_r <= kind_t'(in_tuser[1:0]);
      s0_dx_r   <= {in_bx[31], in_bx} - {in_ax[31], in_ax};
      s0_dy_r   <= {in_by[31], in_by} - {in_ay[31], in_ay};
      s0_xmin_r <= {in_ax[31], in_ax} - {2'b00, in_ahw};
      s0_xmax_r <= {in_ax[31], in_ax} + {2'b00, in_ahw};
      s0_ymin_r <= {in_ay[31], in_ay} - {2'b00, in_ahh};
      s0_ymax_r <= {in_ay[31], in_ay} + {2'b00, in_ahh};
      s0_rs_r   <= {1'b0, in_ahw} + {1'b0, in_bhw};
      s0_rh_r   <= {1'b0, in_ahh} + {1'b0, in_bhh};
      s0_bx_r   <= in_bx;
      s0_by_r   <= in_by;
      s0_ahw_r  <= in_ahw;
      s0_bhw_r  <= in_bhw;
    end
  end

  // Stage 1: box overlaps and distances of circle B's centre to each box side.
  kind_t              s1_kind_r;
  logic signed [32:0] s1_dx_r, s1_dy_r;
  logic signed [33:0] s1_xo_r, s1_yo_r, s1_left_r, s1_right_r, s1_bottom_r, s1_top_r;
  logic        [31:0] s1_rs_r;
  logic        [30:0] s1_ahw_r, s1_bhw_r;
  logic        [32:0] s1_adx, s1_ady;

  assign s1_adx = s0_dx_r[32] ? 33'(-s0_dx_r) : 33'(s0_dx_r);
  assign s1_ady = s0_dy_r[32] ? 33'(-s0_dy_r) : 33'(s0_dy_r);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_kind_r   <= s0_kind_r;
      s1_dx_r     <= s0_dx_r;
      s1_dy_r     <= s0_dy_r;
      s1_xo_r     <= {2'b00, s0_rs_r} - {1'b0, s1_adx};
      s1_yo_r     <= {2'b00, s0_rh_r} - {1'b0, s1_ady};
      s1_left_r   <= {{2{s0_bx_r[31]}}, s0_bx_r} - {s0_xmin_r[32], s0_xmin_r};
      s1_right_r  <= {s0_xmax_r[32], s0_xmax_r} - {{2{s0_bx_r[31]}}, s0_bx_r};
      s1_bottom_r <= {{2{s0_by_r[31]}}, s0_by_r} - {s0_ymin_r[32], s0_ymin_r};
      s1_top_r    <= {s0_ymax_r[32], s0_ymax_r} - {{2{s0_by_r[31]}}, s0_by_r};
      s1_rs_r     <= s0_rs_r;
      s1_ahw_r    <= s0_ahw_r;
      s1_bhw_r    <= s0_bhw_r;
    end
  end

  // Stage 2: per-kind decode of the box result, the vector to test and the fallback
  // used when that vector has zero length.
  logic               s2_round_nxt, s2_hit_nxt;
  logic signed [17:0] s2_nx_nxt, s2_ny_nxt;
  logic signed [31:0] s2_pen_nxt;
  logic signed [33:0] s2_dvx_nxt, s2_dvy_nxt, s2_zbest_nxt;
  logic        [31:0] s2_lim_nxt;
  logic        [30:0] s2_zadd_nxt;
  logic signed [33:0] best;
  logic signed [17:0] fb_nx, fb_ny;

  always_comb begin
    // Inside the box: nearest side wins, left, right, bottom, top in that order.
    best  = s1_left_r;
    fb_nx = NEG_ONE_Q16;
    fb_ny = '0;
    if (s1_right_r < best) begin
      best  = s1_right_r;
      fb_nx = ONE_Q16;
      fb_ny = '0;
    end
    if (s1_bottom_r < best) begin
      best  = s1_bottom_r;
      fb_nx = '0;
      fb_ny = NEG_ONE_Q16;
    end
    if (s1_top_r < best) begin
      best  = s1_top_r;
      fb_nx = '0;
      fb_ny = ONE_Q16;
    end

    s2_round_nxt = 1'b0;
    s2_hit_nxt   = 1'b0;
    s2_nx_nxt    = '0;
    s2_ny_nxt    = '0;
    s2_pen_nxt   = '0;
    s2_dvx_nxt   = '0;
    s2_dvy_nxt   = '0;
    s2_lim_nxt   = '0;
    s2_zadd_nxt  = '0;
    s2_zbest_nxt = '0;
    unique case (s1_kind_r)
      KIND_CIRCLE: begin
        s2_round_nxt = 1'b1;
        s2_dvx_nxt   = {s1_dx_r[32], s1_dx_r};
        s2_dvy_nxt   = {s1_dy_r[32], s1_dy_r};
        s2_lim_nxt   = s1_rs_r;
        s2_nx_nxt    = ONE_Q16;
        s2_zbest_nxt = {3'b000, s1_ahw_r};
      end
      KIND_BOX: begin
        if (s1_xo_r > 34'sd0 && s1_yo_r > 34'sd0) begin
          s2_hit_nxt = 1'b1;
          if (s1_xo_r < s1_yo_r) begin
            s2_nx_nxt  = s1_dx_r[32] ? NEG_ONE_Q16 : ONE_Q16;
            s2_pen_nxt = sat_q16(36'(s1_xo_r));
          end else begin
            s2_ny_nxt  = s1_dy_r[32] ? NEG_ONE_Q16 : ONE_Q16;
            s2_pen_nxt = sat_q16(36'(s1_yo_r));
          end
        end
      end
      KIND_BOX_CIRCLE: begin
        s2_round_nxt = 1'b1;
        // Offset of the circle centre from its clamp onto the box.
        s2_dvx_nxt   = s1_left_r[33] ? s1_left_r : (s1_right_r[33] ? -s1_right_r : '0);
        s2_dvy_nxt   = s1_bottom_r[33] ? s1_bottom_r : (s1_top_r[33] ? -s1_top_r : '0);
        s2_lim_nxt   = {1'b0, s1_bhw_r};
        s2_nx_nxt    = fb_nx;
        s2_ny_nxt    = fb_ny;
        s2_zadd_nxt  = s1_bhw_r;
        s2_zbest_nxt = best;
      end
      KIND_NONE: begin
        s2_round_nxt = 1'b0;
      end
      default: begin
        s2_round_nxt = 1'b0;
      end
    endcase
  end

  logic               s2_round_r, s2_hit_r;
  logic signed [17:0] s2_nx_r, s2_ny_r;
  logic signed [31:0] s2_pen_r;
  logic signed [33:0] s2_dvx_r, s2_dvy_r, s2_zbest_r;
  logic        [31:0] s2_lim_r;
  logic        [30:0] s2_zadd_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_round_r <= s2_round_nxt;
      s2_hit_r   <= s2_hit_nxt;
      s2_nx_r    <= s2_nx_nxt;
      s2_ny_r    <= s2_ny_nxt;
      s2_pen_r   <= s2_pen_nxt;
      s2_dvx_r   <= s2_dvx_nxt;
      s2_dvy_r   <= s2_dvy_nxt;
      s2_lim_r   <= s2_lim_nxt;
      s2_zadd_r  <= s2_zadd_nxt;
      s2_zbest_r <= s2_zbest_nxt;
    end
  end

  // Stage 3: magnitudes, range check against the limit, fallback depth.
  carry_t      car_r [3:S_DVL];
  logic [33:0] s3_adx, s3_ady;
  assign s3_adx = s2_dvx_r[33] ? 34'(-s2_dvx_r) : 34'(s2_dvx_r);
  assign s3_ady = s2_dvy_r[33] ? 34'(-s2_dvy_r) : 34'(s2_dvy_r);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      car_r[3].round <= s2_round_r;
      car_r[3].ok    <= (s3_adx <= {2'b00, s2_lim_r}) && (s3_ady <= {2'b00, s2_lim_r});
      car_r[3].hit   <= s2_hit_r;
      car_r[3].sgx   <= s2_dvx_r[33];
      car_r[3].sgy   <= s2_dvy_r[33];
      car_r[3].nx    <= s2_nx_r;
      car_r[3].ny    <= s2_ny_r;
      car_r[3].pen   <= s2_round_r ?
                        sat_q16($signed({5'b00000, s2_zadd_r}) + 36'(s2_zbest_r)) : s2_pen_r;
      car_r[3].lim   <= s2_lim_r;
      car_r[3].ax    <= s3_adx[31:0];
      car_r[3].ay    <= s3_ady[31:0];
    end
  end

  // Stage 4: squares.
  logic [63:0] a2_r, b2_r, l2_r;
  always_ff @(posedge clk) begin
    if (en[4]) begin
      car_r[4] <= car_r[3];
      a2_r     <= car_r[3].ax * car_r[3].ax;
      b2_r     <= car_r[3].ay * car_r[3].ay;
      l2_r     <= car_r[3].lim * car_r[3].lim;
    end
  end

  // Stage 5: squared distance and the overlap decision for round shapes.
  logic [63:0] sn_r   [5:S_SQL];
  logic [63:0] sres_r [5:S_SQL];
  logic [64:0] s5_sum;
  carry_t      s5_car_nxt;
  assign s5_sum = {1'b0, a2_r} + {1'b0, b2_r};

  always_comb begin
    s5_car_nxt     = car_r[4];
    s5_car_nxt.hit = car_r[4].round ? (car_r[4].ok && (s5_sum <= {1'b0, l2_r}))
                                    : car_r[4].hit;
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      car_r[5]  <= s5_car_nxt;
      sn_r[5]   <= s5_sum[63:0];
      sres_r[5] <= '0;
    end
  end

  // Square root, one result bit per stage.
  generate
    for (g = S_SQ0; g <= S_SQL; g++) begin : g_sqrt
      localparam logic [63:0] BIT = 64'(1) << (62 - 2 * (g - S_SQ0));
      logic [63:0] trial;
      assign trial = sres_r[g-1] + BIT;
      always_ff @(posedge clk) begin
        if (en[g]) begin
          car_r[g] <= car_r[g-1];
          if (sn_r[g-1] >= trial) begin
            sn_r[g]   <= sn_r[g-1] - trial;
            sres_r[g] <= (sres_r[g-1] >> 1) + BIT;
          end else begin
            sn_r[g]   <= sn_r[g-1];
            sres_r[g] <= sres_r[g-1] >> 1;
          end
        end
      end
    end
  endgenerate

  // Normal components: restoring division of |d| * 65536 by the distance.
  logic [48:0] rx_r   [S_DV0:S_DVL];
  logic [48:0] ry_r   [S_DV0:S_DVL];
  logic [16:0] qx_r   [S_DV0:S_DVL];
  logic [16:0] qy_r   [S_DV0:S_DVL];
  logic [31:0] dist_r [S_DV0:S_DVL];

  generate
    for (g = S_DV0; g <= S_DVL; g++) begin : g_div
      localparam int KK = DV_N - 1 - (g - S_DV0);
      logic [48:0] rx_src, ry_src, dsh;
      logic [16:0] qx_src, qy_src;
      logic [31:0] d_src;
      logic        gex, gey;
      if (g == S_DV0) begin : g_first
        assign rx_src = {1'b0, car_r[g-1].ax, 16'h0000};
        assign ry_src = {1'b0, car_r[g-1].ay, 16'h0000};
        assign qx_src = '0;
        assign qy_src = '0;
        assign d_src  = sres_r[S_SQL][31:0];
      end else begin : g_next
        assign rx_src = rx_r[g-1];
        assign ry_src = ry_r[g-1];
        assign qx_src = qx_r[g-1];
        assign qy_src = qy_r[g-1];
        assign d_src  = dist_r[g-1];
      end
      assign dsh = {17'h00000, d_src} << KK;
      assign gex = rx_src >= dsh;
      assign gey = ry_src >= dsh;
      always_ff @(posedge clk) begin
        if (en[g]) begin
          car_r[g]  <= car_r[g-1];
          dist_r[g] <= d_src;
          rx_r[g]   <= gex ? rx_src - dsh : rx_src;
          ry_r[g]   <= gey ? ry_src - dsh : ry_src;
          qx_r[g]   <= {qx_src[15:0], gex};
          qy_r[g]   <= {qy_src[15:0], gey};
        end
      end
    end
  endgenerate

  // Output stage.
  carry_t             oc;
  logic [32:0]        pen_diff;
  logic               out_col_r;
  logic signed [17:0] out_nx_r, out_ny_r;
  logic signed [31:0] out_pen_r;
  assign oc       = car_r[S_DVL];
  assign pen_diff = {1'b0, oc.lim} - {1'b0, dist_r[S_DVL]};

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      if (!oc.round) begin
        out_col_r <= oc.hit;
        out_nx_r  <= oc.nx;
        out_ny_r  <= oc.ny;
        out_pen_r <= oc.pen;
      end else if (!oc.hit) begin
        out_col_r <= 1'b0;
        out_nx_r  <= '0;
        out_ny_r  <= '0;
        out_pen_r <= '0;
      end else if (dist_r[S_DVL] == 32'h0) begin
        out_col_r <= 1'b1;
        out_nx_r  <= oc.nx;
        out_ny_r  <= oc.ny;
        out_pen_r <= oc.pen;
      end else begin
        out_col_r <= 1'b1;
        out_nx_r  <= oc.sgx ? -$signed({1'b0, qx_r[S_DVL]}) : $signed({1'b0, qx_r[S_DVL]});
        out_ny_r  <= oc.sgy ? -$signed({1'b0, qy_r[S_DVL]}) : $signed({1'b0, qy_r[S_DVL]});
        out_pen_r <= sat_q16($signed({3'b000, pen_diff}));
      end
    end
  end

  assign out_tdata = {3'b000, out_pen_r, out_ny_r, out_nx_r, out_col_r};

`ifndef SYNTHESIS
  a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[68:1] == '0)
    else $error("non-colliding result carries a normal or depth");

  a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_nx_r <= ONE_Q16 && out_nx_r >= NEG_ONE_Q16
                   && out_ny_r <= ONE_Q16 && out_ny_r >= NEG_ONE_Q16)
    else $error("normal component outside unit range");

  a_sqrt_width: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[S_SQL] |-> sres_r[S_SQL][63:32] == '0)
    else $error("square root result wider than 32 bits");

  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[S_DVL] && oc.round && oc.hit && dist_r[S_DVL] != 32'h0
      |-> qx_r[S_DVL] <= 17'd65536 && qy_r[S_DVL] <= 17'd65536)
    else $error("normal quotient exceeds one");
`endif

endmodule
`default_nettype wire
